FILE: rtl/pipw_pkg.sv
// shared types and constants for the winding-number point-in-polygon block
// no dependencies; used by every module under rtl

package pipw_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int COORD_BITS   = 16;
  localparam int INDEX_BITS   = 6;
  localparam int VCOUNT_BITS  = 7;

  localparam int RING_BITS  = $clog2(MAX_VERTICES);
  localparam int CNT_MIN    = $clog2(MAX_VERTICES + 1);
  localparam int CNT_BITS   = (CNT_MIN > VCOUNT_BITS) ? CNT_MIN : VCOUNT_BITS;
  localparam int DIFF_BITS  = COORD_BITS + 1;
  localparam int PROD_BITS  = 2 * DIFF_BITS;
  localparam int CROSS_BITS = PROD_BITS + 1;
  localparam int WN_BITS    = CNT_BITS + 1;

  localparam int IN_FIELD_BITS = INDEX_BITS + 2 * COORD_BITS;
  localparam int IN_DATA_BITS  = ((IN_FIELD_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_BITS = 8;

  localparam int CFG_INDEX_BITS = 1;
  localparam int CFG_DATA_BITS  = VCOUNT_BITS;

  localparam logic [CFG_INDEX_BITS-1:0] REG_VERTEX_COUNT = 1'b0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_CHECK_ALL    = 1'b1;

  localparam logic OP_VERTEX = 1'b0;
  localparam logic OP_TEST   = 1'b1;

  localparam int DRAIN_CYCLES = 2;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
  } vertex_t;

  typedef struct packed {
    logic    valid;
    vertex_t v0;
    vertex_t v1;
    vertex_t p;
  } edge_feed_t;

endpackage

FILE: rtl/pipw_cell.sv
// one vertex cell of the rotating ring: loads a written vertex or takes its neighbor's
// depends on pipw_pkg

module pipw_cell (
  input  logic              clk,
  input  logic              load,
  input  logic              shift,
  input  pipw_pkg::vertex_t load_vertex,
  input  pipw_pkg::vertex_t neighbor,
  output pipw_pkg::vertex_t vertex
);

  always_ff @(posedge clk) begin
    if (load) begin
      vertex <= load_vertex;
    end else if (shift) begin
      vertex <= neighbor;
    end
  end

endmodule

FILE: rtl/pipw_edge.sv
// edge crossing pipeline: differences, two products, cross sign and winding sum
// depends on pipw_pkg

module pipw_edge (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  pipw_pkg::edge_feed_t feed,
  output logic                 wound
);

  logic                                   s1_valid;
  logic                                   s1_up;
  logic                                   s1_down;
  logic signed [pipw_pkg::DIFF_BITS-1:0]  s1_dx;
  logic signed [pipw_pkg::DIFF_BITS-1:0]  s1_dyp;
  logic signed [pipw_pkg::DIFF_BITS-1:0]  s1_dxp;
  logic signed [pipw_pkg::DIFF_BITS-1:0]  s1_dy;

  logic                                   s2_valid;
  logic                                   s2_up;
  logic                                   s2_down;
  logic signed [pipw_pkg::PROD_BITS-1:0]  s2_p1;
  logic signed [pipw_pkg::PROD_BITS-1:0]  s2_p2;

  logic signed [pipw_pkg::CROSS_BITS-1:0] cross_sum;
  logic                                   cross_ge;
  logic                                   cross_le;
  logic signed [pipw_pkg::WN_BITS-1:0]    wn;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= feed.valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_up   <= (feed.v0.y <= feed.p.y) && (feed.v1.y > feed.p.y);
    s1_down <= (feed.v0.y > feed.p.y) && (feed.v1.y <= feed.p.y);
    s1_dx   <= pipw_pkg::DIFF_BITS'(feed.v1.x) - pipw_pkg::DIFF_BITS'(feed.v0.x);
    s1_dyp  <= pipw_pkg::DIFF_BITS'(feed.p.y) - pipw_pkg::DIFF_BITS'(feed.v0.y);
    s1_dxp  <= pipw_pkg::DIFF_BITS'(feed.p.x) - pipw_pkg::DIFF_BITS'(feed.v0.x);
    s1_dy   <= pipw_pkg::DIFF_BITS'(feed.v1.y) - pipw_pkg::DIFF_BITS'(feed.v0.y);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s2_up   <= s1_up;
    s2_down <= s1_down;
    s2_p1   <= s1_dx * s1_dyp;
    s2_p2   <= s1_dxp * s1_dy;
  end

  assign cross_sum = pipw_pkg::CROSS_BITS'(s2_p1) - pipw_pkg::CROSS_BITS'(s2_p2);
  assign cross_ge  = !cross_sum[pipw_pkg::CROSS_BITS-1];
  assign cross_le  = cross_sum[pipw_pkg::CROSS_BITS-1] || (cross_sum == '0);

  always_ff @(posedge clk) begin
    if (rst || start) begin
      wn <= '0;
    end else if (s2_valid && s2_up && cross_ge) begin
      wn <= wn + pipw_pkg::WN_BITS'(1);
    end else if (s2_valid && s2_down && cross_le) begin
      wn <= wn - pipw_pkg::WN_BITS'(1);
    end
  end

  assign wound = (wn != '0);

endmodule

FILE: rtl/point_in_polygon_winding.sv
// top level of the winding-number point-in-polygon block
// depends on pipw_pkg, pipw_cell (vertex ring) and pipw_edge (crossing pipeline)
//
// channel  dir  handshake          payload
// s_*      in   s_tvalid/s_tready  tuser operation, tdata index/x/y, tlast last point
// m_*      out  m_tvalid/m_tready  tdata point_inside, tlast last result
// cfg_*    in   cfg_valid/cfg_ready cfg_index register, cfg_data value
//
// a tested point is handled by the ring of vertex cells rotating one edge per cycle past
// the single crossing unit, then the two-stage pipeline drain and the finish state; a
// skipped point in stop mode bypasses the ring walk
// reset clears control state only; the vertex ring is undefined until written
// a finished result waits in the output register; a new item is taken meanwhile and
// stalls only in its finish state if the previous result has not been transferred

module point_in_polygon_winding (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [pipw_pkg::IN_DATA_BITS-1:0]    s_tdata,  // vertex_index, coord_x, coord_y
  input  logic                                 s_tuser,  // operation
  input  logic                                 s_tlast,  // last_point
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [pipw_pkg::OUT_DATA_BITS-1:0]   m_tdata,  // point_inside
  output logic                                 m_tlast,  // last_result
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [pipw_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [pipw_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_FIN   = 2'd3;

  logic [1:0]                         state;
  logic [1:0]                         state_next;
  logic [pipw_pkg::RING_BITS-1:0]     step;
  logic [1:0]                         drain;
  logic [pipw_pkg::VCOUNT_BITS-1:0]   vertex_count;
  logic                               every_mode;
  logic                               all_inside;
  logic                               run_every;
  logic                               run_last;
  logic                               run_skip;
  pipw_pkg::vertex_t                  point;
  logic                               out_inside;

  logic                               in_xfer;
  logic                               is_test;
  logic                               skip_now;
  logic                               start_run;
  logic                               shift;
  logic                               emit_need;
  logic                               fin_go;
  logic                               result;
  logic                               wound;
  logic [pipw_pkg::INDEX_BITS-1:0]    in_index;
  pipw_pkg::vertex_t                  in_vertex;
  logic [pipw_pkg::CNT_BITS-1:0]      n_edges_lim;
  logic [pipw_pkg::CNT_BITS-1:0]      step_plus;
  pipw_pkg::edge_feed_t               feed;
  pipw_pkg::vertex_t                  ring [pipw_pkg::MAX_VERTICES];

  assign in_index    = s_tdata[pipw_pkg::INDEX_BITS-1:0];
  assign in_vertex.x = s_tdata[pipw_pkg::INDEX_BITS +: pipw_pkg::COORD_BITS];
  assign in_vertex.y = s_tdata[pipw_pkg::INDEX_BITS + pipw_pkg::COORD_BITS +:
                               pipw_pkg::COORD_BITS];

  assign s_tready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_xfer   = s_tvalid && s_tready;
  assign is_test   = (s_tuser == pipw_pkg::OP_TEST);
  assign skip_now  = !every_mode && !all_inside;
  assign start_run = in_xfer && is_test && !skip_now;
  assign shift     = (state == ST_RUN);

  // vertex ring, cell i takes cell i+1 so the head walks the edges in order
  for (genvar i = 0; i < pipw_pkg::MAX_VERTICES; i++) begin : g_cell
    pipw_cell u_cell (
      .clk         (clk),
      .load        (in_xfer && !is_test && (int'(in_index) == i)),
      .shift       (shift),
      .load_vertex (in_vertex),
      .neighbor    (ring[(i + 1) % pipw_pkg::MAX_VERTICES]),
      .vertex      (ring[i])
    );
  end

  assign n_edges_lim = (pipw_pkg::CNT_BITS'(vertex_count) >
                        pipw_pkg::CNT_BITS'(pipw_pkg::MAX_VERTICES)) ?
                       pipw_pkg::CNT_BITS'(pipw_pkg::MAX_VERTICES) :
                       pipw_pkg::CNT_BITS'(vertex_count);
  assign step_plus   = pipw_pkg::CNT_BITS'(step) + pipw_pkg::CNT_BITS'(1);

  assign feed.valid = shift && (step_plus < n_edges_lim);
  assign feed.v0    = ring[0];
  assign feed.v1    = ring[1];
  assign feed.p     = point;

  pipw_edge u_edge (
    .clk    (clk),
    .rst    (rst),
    .start  (start_run),
    .feed   (feed),
    .wound  (wound)
  );

  assign result    = run_skip ? 1'b0 : wound;
  assign emit_need = run_every || run_last;
  assign fin_go    = (state == ST_FIN) && (!emit_need || !m_tvalid || m_tready);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_xfer && is_test) begin
          if (!skip_now) begin
            state_next = ST_RUN;
          end else if (s_tlast) begin
            state_next = ST_FIN;
          end
        end
      end
      ST_RUN: begin
        if (step == pipw_pkg::RING_BITS'(pipw_pkg::MAX_VERTICES - 1)) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (drain == 2'(pipw_pkg::DRAIN_CYCLES - 1)) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        if (fin_go) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step  <= '0;
      drain <= '0;
    end else begin
      if (start_run) begin
        step <= '0;
      end else if (shift) begin
        step <= step + pipw_pkg::RING_BITS'(1);
      end
      if (state == ST_DRAIN) begin
        drain <= drain + 2'd1;
      end else begin
        drain <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= '0;
      every_mode   <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        pipw_pkg::REG_VERTEX_COUNT: vertex_count <= cfg_data;
        pipw_pkg::REG_CHECK_ALL:    every_mode   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && is_test) begin
      run_every <= every_mode;
      run_last  <= s_tlast;
      run_skip  <= skip_now;
      point     <= in_vertex;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      all_inside <= 1'b1;
    end else if (fin_go) begin
      if (run_last) begin
        all_inside <= 1'b1;
      end else if (!run_every) begin
        all_inside <= result;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fin_go && emit_need) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_go && emit_need) begin
      out_inside <= result;
      m_tlast    <= run_last;
    end
  end

  assign m_tdata = pipw_pkg::OUT_DATA_BITS'(out_inside);

  a_run_ends: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN && step == pipw_pkg::RING_BITS'(pipw_pkg::MAX_VERTICES - 1))
    |=> (state == ST_DRAIN))
    else $error("ring walk did not end after a full rotation");

  a_emit_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == ST_FIN))
    else $error("result raised outside the finish step");

  a_flag_stop_only: assert property (@(posedge clk) disable iff (rst)
    $fell(all_inside) |-> $past(!run_every && !run_last))
    else $error("aggregate flag cleared outside stop mode");

  a_feed_in_run: assert property (@(posedge clk) disable iff (rst)
    feed.valid |-> (state == ST_RUN && !s_tready))
    else $error("edge fed while not walking the ring");

endmodule
